/* hdl/rail_fence_transposition_defines.svh */
// Assertion macros shared by the rail fence transposition RTL.
`ifndef RAIL_FENCE_TRANSPOSITION_DEFINES_SVH
`define RAIL_FENCE_TRANSPOSITION_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check, held off while reset is asserted.
`define RFT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rail fence assertion failed");
// Clocked check that also holds during reset.
`define RFT_ASSERT_NORST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("rail fence assertion failed");
`else
`define RFT_ASSERT(lbl, clk, rst_n, prop)
`define RFT_ASSERT_NORST(lbl, clk, prop)
`endif

`endif

/* hdl/rft_pkg.sv */
// Package: sizes, descriptor and control types, rail clamp for the rail fence block.
`default_nettype none

package rft_pkg;

  localparam int unsigned MaxLen   = 64;
  localparam int unsigned MaxRails = 16;

  localparam int unsigned CharW  = 8;
  localparam int unsigned LenW   = $clog2(MaxLen + 1);
  localparam int unsigned IdxW   = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned BufAw  = IdxW + 1;
  localparam int unsigned BufDepth = 2 * (1 << IdxW);
  localparam int unsigned ResDepth = 1 << IdxW;
  localparam int unsigned RailsW = 5;
  localparam int unsigned RowW   = (MaxRails > 1) ? $clog2(MaxRails) : 1;
  localparam int unsigned StepW  = RailsW + 1;
  localparam int unsigned CandW  = ((StepW + 1) > LenW) ? (StepW + 1) : LenW;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgRails = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgMode  = CfgIdxW'(1);

  localparam logic [RailsW-1:0] RailsReset = RailsW'(2);

  // One loaded block waiting for the back end
  typedef struct packed {
    logic [LenW-1:0] len;
    logic            ovf;
    logic            bank;
  } desc_t;

  // Settings the back end works with
  typedef struct packed {
    logic [RailsW-1:0] rails;
    logic              decrypt;
  } ctrl_t;

  // One result item
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
    logic             ovf;
  } res_t;

  // Zero counts as one rail, large values saturate.
  function automatic logic [RailsW-1:0] eff_rails(input logic [RailsW-1:0] r);
    logic [RailsW-1:0] e;
    e = r;
    if (r == '0) begin
      e = RailsW'(1);
    end else if (r > RailsW'(MaxRails)) begin
      e = RailsW'(MaxRails);
    end
    return e;
  endfunction

endpackage

`default_nettype wire

/* hdl/rft_if.sv */
// Channel interfaces: character input, result output, configuration writes.
`default_nettype none

interface rft_in_if;
  logic                      valid;
  logic                      ready;
  logic [rft_pkg::CharW-1:0] in_char;
  logic                      in_last;
  modport source (output valid, in_char, in_last, input ready);
  modport sink   (input valid, in_char, in_last, output ready);
endinterface

interface rft_out_if;
  logic                      valid;
  logic                      ready;
  logic [rft_pkg::CharW-1:0] out_char;
  logic                      out_last;
  logic                      overflow;
  modport source (output valid, out_char, out_last, overflow, input ready);
  modport sink   (input valid, out_char, out_last, overflow, output ready);
endinterface

interface rft_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [rft_pkg::CfgIdxW-1:0]  index;
  logic [rft_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hdl/rft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hdl/rft_front.sv */
// Front end: accept characters, store them into the current bank, hand off blocks.
`default_nettype none

module rft_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  rft_in_if.sink                      in_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output rft_pkg::desc_t              q_desc_o,
  output logic                        buf_we_o,
  output logic [rft_pkg::BufAw-1:0]   buf_waddr_o,
  output logic [rft_pkg::CharW-1:0]   buf_wdata_o
);

  logic [rft_pkg::LenW-1:0] fill_q, fill_d;
  logic                     ovf_q, ovf_d;
  logic                     bank_q, bank_d;
  logic                     accept;
  logic                     room;

  // Both banks busy means the queue is full: hold the input.
  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign room       = fill_q < rft_pkg::LenW'(rft_pkg::MaxLen);

  assign buf_we_o    = accept && room;
  assign buf_waddr_o = {bank_q, fill_q[rft_pkg::IdxW-1:0]};
  assign buf_wdata_o = in_i.in_char;

  assign q_push_o = accept && in_i.in_last;

  always_comb begin
    q_desc_o.len  = fill_q + rft_pkg::LenW'(room);
    q_desc_o.ovf  = ovf_q || !room;
    q_desc_o.bank = bank_q;
  end

  always_comb begin
    fill_d = fill_q;
    ovf_d  = ovf_q;
    bank_d = bank_q;
    if (accept) begin
      if (in_i.in_last) begin
        fill_d = '0;
        ovf_d  = 1'b0;
        bank_d = !bank_q;
      end else begin
        fill_d = fill_q + rft_pkg::LenW'(room);
        ovf_d  = ovf_q || !room;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/rft_queue.sv */
// Two-entry block descriptor queue; the head stays until the back end retires it.
`default_nettype none
`include "rail_fence_transposition_defines.svh"

module rft_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rft_pkg::desc_t push_desc_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output rft_pkg::desc_t head_o
);

  rft_pkg::desc_t ent_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     cnt_q;

  assign full_o       = cnt_q == 2'd2;
  assign head_valid_o = cnt_q != 2'd0;
  assign head_o       = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  `RFT_ASSERT(a_no_push_when_full, clk_i, rst_ni, push_i |-> !full_o)
  `RFT_ASSERT(a_no_pop_when_empty, clk_i, rst_ni, pop_i |-> head_valid_o)
  `RFT_ASSERT_NORST(a_cnt_in_range, clk_i, (!rst_ni) || (cnt_q != 2'd3))

endmodule

`default_nettype wire

/* hdl/rft_back.sv */
// Back end: walk the zigzag, read or scatter the block, and queue the results.
`default_nettype none
`include "rail_fence_transposition_defines.svh"

module rft_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      desc_valid_i,
  input  rft_pkg::desc_t            desc_i,
  input  rft_pkg::ctrl_t            ctrl_i,
  output logic                      pop_o,
  output logic                      buf_re_o,
  output logic [rft_pkg::BufAw-1:0] buf_raddr_o,
  input  logic [rft_pkg::CharW-1:0] buf_rdata_i,
  rft_out_if.source                 out_o
);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StEnc   = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StFlush = 3'd3;
  localparam logic [2:0] StEmit  = 3'd4;

  localparam logic SrcBuf = 1'b0;
  localparam logic SrcRes = 1'b1;

  logic [2:0]                state_q, state_d;
  logic [rft_pkg::LenW-1:0]  cnt_q, cnt_d;
  logic [rft_pkg::RowW-1:0]  row_q, row_d;
  logic [rft_pkg::IdxW-1:0]  pos_q, pos_d;
  logic                      phase_q, phase_d;

  // zigzag walker
  logic [rft_pkg::StepW-1:0] cyc, twice_row, step_a, step_b, step;
  logic [rft_pkg::CandW-1:0] cand;
  logic [rft_pkg::RowW-1:0]  row_inc;
  logic [rft_pkg::IdxW-1:0]  gen_pos;
  logic [rft_pkg::RowW-1:0]  gen_row;
  logic                      gen_phase;
  logic                      last_k;

  // read tags and scratch write
  logic                      out_issue, scan_issue, out_src;
  logic                      rd_pend_q, rd_last_q, rd_ovf_q, rd_src_q;
  logic                      wr_pend_q;
  logic [rft_pkg::IdxW-1:0]  wr_addr_q;
  logic                      res_re;
  logic [rft_pkg::IdxW-1:0]  res_raddr;
  logic [rft_pkg::CharW-1:0] res_rdata;

  // result queue
  rft_pkg::res_t             ent_q [2];
  rft_pkg::res_t             push_res;
  logic                      owr_q, ord_q;
  logic [1:0]                out_cnt_q;
  logic [1:0]                occ;
  logic                      out_pop;
  logic                      credit_ok;

  assign cyc       = rft_pkg::StepW'({ctrl_i.rails - rft_pkg::RailsW'(1), 1'b0});
  assign twice_row = rft_pkg::StepW'({row_q, 1'b0});
  assign step_a    = cyc - twice_row;
  assign step_b    = twice_row;

  always_comb begin
    if (ctrl_i.rails == rft_pkg::RailsW'(1)) begin
      step = rft_pkg::StepW'(1);
    end else if (phase_q) begin
      step = (step_b == '0) ? cyc : step_b;
    end else begin
      step = (step_a == '0) ? cyc : step_a;
    end
  end

  assign cand    = rft_pkg::CandW'(pos_q) + rft_pkg::CandW'(step);
  assign row_inc = row_q + rft_pkg::RowW'(1);

  // Stay on the rail while the next position is inside the block, else drop to the next rail.
  always_comb begin
    if (cand < rft_pkg::CandW'(desc_i.len)) begin
      gen_pos   = cand[rft_pkg::IdxW-1:0];
      gen_row   = row_q;
      gen_phase = !phase_q;
    end else begin
      gen_pos   = rft_pkg::IdxW'(row_inc);
      gen_row   = row_inc;
      gen_phase = 1'b0;
    end
  end

  assign last_k = cnt_q == (desc_i.len - rft_pkg::LenW'(1));

  assign out_pop   = out_o.valid && out_o.ready;
  assign occ       = out_cnt_q + 2'(rd_pend_q) - 2'(out_pop);
  assign credit_ok = !occ[1];

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    row_d       = row_q;
    pos_d       = pos_q;
    phase_d     = phase_q;
    buf_re_o    = 1'b0;
    buf_raddr_o = {desc_i.bank, pos_q};
    res_re      = 1'b0;
    res_raddr   = cnt_q[rft_pkg::IdxW-1:0];
    out_issue   = 1'b0;
    out_src     = SrcBuf;
    scan_issue  = 1'b0;
    pop_o       = 1'b0;
    case (state_q)
      StIdle: begin
        if (desc_valid_i) begin
          cnt_d   = '0;
          row_d   = '0;
          pos_d   = '0;
          phase_d = 1'b0;
          state_d = ctrl_i.decrypt ? StScan : StEnc;
        end
      end
      StEnc: begin
        if (credit_ok) begin
          buf_re_o  = 1'b1;
          out_issue = 1'b1;
          if (last_k) begin
            pop_o   = 1'b1;
            state_d = StIdle;
          end else begin
            cnt_d   = cnt_q + rft_pkg::LenW'(1);
            row_d   = gen_row;
            pos_d   = gen_pos;
            phase_d = gen_phase;
          end
        end
      end
      StScan: begin
        buf_re_o    = 1'b1;
        buf_raddr_o = {desc_i.bank, cnt_q[rft_pkg::IdxW-1:0]};
        scan_issue  = 1'b1;
        if (last_k) begin
          cnt_d   = '0;
          state_d = StFlush;
        end else begin
          cnt_d   = cnt_q + rft_pkg::LenW'(1);
          row_d   = gen_row;
          pos_d   = gen_pos;
          phase_d = gen_phase;
        end
      end
      StFlush: begin
        state_d = StEmit;
      end
      StEmit: begin
        if (credit_ok) begin
          res_re    = 1'b1;
          out_issue = 1'b1;
          out_src   = SrcRes;
          if (last_k) begin
            pop_o   = 1'b1;
            state_d = StIdle;
          end else begin
            cnt_d = cnt_q + rft_pkg::LenW'(1);
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      row_q     <= '0;
      pos_q     <= '0;
      phase_q   <= 1'b0;
      rd_pend_q <= 1'b0;
      wr_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      row_q     <= row_d;
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      rd_pend_q <= out_issue;
      wr_pend_q <= scan_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_issue) begin
      rd_last_q <= last_k;
      rd_ovf_q  <= desc_i.ovf;
      rd_src_q  <= out_src;
    end
    if (scan_issue) begin
      wr_addr_q <= pos_q;
    end
  end

  // Scratch block for decrypt: scatter in scan, read back in order in emit.
  rft_ram #(
    .Width (rft_pkg::CharW),
    .Depth (rft_pkg::ResDepth)
  ) u_res_ram (
    .clk_i   (clk_i),
    .we_i    (wr_pend_q),
    .waddr_i (wr_addr_q),
    .wdata_i (buf_rdata_i),
    .re_i    (res_re),
    .raddr_i (res_raddr),
    .rdata_o (res_rdata)
  );

  always_comb begin
    push_res.ch   = (rd_src_q == SrcRes) ? res_rdata : buf_rdata_i;
    push_res.last = rd_last_q;
    push_res.ovf  = rd_ovf_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_pend_q) begin
      ent_q[owr_q] <= push_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q     <= 1'b0;
      ord_q     <= 1'b0;
      out_cnt_q <= 2'd0;
    end else begin
      if (rd_pend_q) begin
        owr_q <= !owr_q;
      end
      if (out_pop) begin
        ord_q <= !ord_q;
      end
      out_cnt_q <= out_cnt_q + 2'(rd_pend_q) - 2'(out_pop);
    end
  end

  assign out_o.valid    = out_cnt_q != 2'd0;
  assign out_o.out_char = ent_q[ord_q].ch;
  assign out_o.out_last = ent_q[ord_q].last;
  assign out_o.overflow = ent_q[ord_q].ovf;

  `RFT_ASSERT(a_out_no_overrun, clk_i, rst_ni,
              (out_cnt_q == 2'd2 && !out_pop) |-> !rd_pend_q)
  `RFT_ASSERT(a_flush_after_scan, clk_i, rst_ni,
              (state_q == StFlush) |-> ($past(state_q) == StScan))
  `RFT_ASSERT(a_pos_in_block, clk_i, rst_ni,
              (state_q == StEnc) |-> (rft_pkg::LenW'(pos_q) < desc_i.len))

endmodule

`default_nettype wire

/* hdl/rail_fence_transposition.sv */
// Top level of the rail fence transposition block.
//
//   channel  dir  handshake        payload
//   cfg_i    in   valid / ready    index, data   (index 0 rails, 1 mode)
//   in_i     in   valid / ready    in_char, in_last
//   out_o    out  valid / ready    out_char, out_last, overflow
//
// Flow: a block of n characters loads at one character per cycle while a bank is free.
// Encrypt then emits n results at one per cycle while the result queue has room;
// decrypt first scatters the block into a scratch RAM and then emits n at one per
// cycle under the same condition. Reads of the block RAM share its single read port.
// Loading of the next block overlaps emission of the previous one (two banks).
// Reset clears control state only; the RAMs need no clearing pass.
// Input stalls only while both banks hold unfinished blocks; output stalls back up
// through a two-entry result queue.
`default_nettype none

module rail_fence_transposition (
  input  logic       clk_i,
  input  logic       rst_ni,
  rft_cfg_if.sink    cfg_i,
  rft_in_if.sink     in_i,
  rft_out_if.source  out_o
);

  logic [rft_pkg::RailsW-1:0] rails_q;
  logic                       mode_q;
  rft_pkg::ctrl_t             ctrl;

  logic                       q_push, q_full, q_pop, q_valid;
  rft_pkg::desc_t             q_push_desc, q_head;

  logic                       buf_we, buf_re;
  logic [rft_pkg::BufAw-1:0]  buf_waddr, buf_raddr;
  logic [rft_pkg::CharW-1:0]  buf_wdata, buf_rdata;

  // Configuration writes are registered; unknown indexes drop silently.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rails_q <= rft_pkg::RailsReset;
      mode_q  <= 1'b0;
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        rft_pkg::CfgRails: begin
          rails_q <= cfg_i.data[rft_pkg::RailsW-1:0];
        end
        rft_pkg::CfgMode: begin
          mode_q <= cfg_i.data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp the rail count once here so the walker sees only 1..MaxRails.
  always_comb begin
    ctrl.rails   = rft_pkg::eff_rails(rails_q);
    ctrl.decrypt = mode_q;
  end

  rft_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_desc_o    (q_push_desc),
    .buf_we_o    (buf_we),
    .buf_waddr_o (buf_waddr),
    .buf_wdata_o (buf_wdata)
  );

  // Two banks of one block each; the bank bit is the top address bit.
  rft_ram #(
    .Width (rft_pkg::CharW),
    .Depth (rft_pkg::BufDepth)
  ) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (buf_wdata),
    .re_i    (buf_re),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  // A queue entry lives until the back end has issued its last read, so queue
  // occupancy doubles as the count of banks in use.
  rft_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_desc_i  (q_push_desc),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .head_valid_o (q_valid),
    .head_o       (q_head)
  );

  rft_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .desc_valid_i (q_valid),
    .desc_i       (q_head),
    .ctrl_i       (ctrl),
    .pop_o        (q_pop),
    .buf_re_o     (buf_re),
    .buf_raddr_o  (buf_raddr),
    .buf_rdata_i  (buf_rdata),
    .out_o        (out_o)
  );

endmodule

`default_nettype wire
